[hdl/stmd_pkg.sv]
// stmd_pkg: operation and register codes, sizes and the 5x7 font for the
// scrolling text matrix driver. No dependencies.
package stmd_pkg;

	localparam int MAX_DIGITS_DEF    = 16;
	localparam int GLYPH_ROWS_DEF    = 7;
	localparam int GLYPH_COLUMNS_DEF = 5;
	localparam int TEXT_DEPTH_DEF    = 64;

	localparam logic [7:0] FONT_FIRST = 8'd32;
	localparam logic [7:0] FONT_LAST  = 8'h63;
	localparam logic [7:0] ROW_SELECT_BASE = 8'b0000_0001;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_RENDER  = 2'd1;
	localparam logic [1:0] OP_SCROLL  = 2'd2;
	localparam logic [1:0] OP_REFRESH = 2'd3;

	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_DIGITS = 2'd1;
	localparam logic [1:0] REG_LENGTH = 2'd2;
	localparam logic [1:0] REG_SPEED  = 2'd3;

	typedef logic [55:0] glyph_t;

	// rows 0..6, row 0 in the top byte
	localparam glyph_t FONT [100] = '{
		56'h00000000000000, 56'h20202020000020, 56'h50505000000000, 56'h5050F850F85050,
		56'h2078A07028F020, 56'hC0C810204098_18, 56'h6090A040A89068, 56'h60204000000000,
		56'h10204040402010, 56'h40201010102040, 56'h0020A870A82000, 56'h002020F8202000,
		56'h00000000301020, 56'h0000007C000000, 56'h00000000006060, 56'h00081020408000,
		56'h708898A8C88870, 56'h2060A0202020F8, 56'h708808102040F8, 56'hF8102010088870,
		56'h10305090F81010, 56'hF880F0080808F0, 56'h304080F0888870, 56'hF8081020404040,
		56'h70888870888870, 56'h70888878081060, 56'h00606000606000, 56'h00606000602040,
		56'h08102040201008, 56'h0000F800F80000, 56'h40201008102040, 56'h70880810200020,
		56'h70880868A8A870, 56'h205088F8888888, 56'hF08888F08888F0, 56'h70888080808870,
		56'hE09088888890E0, 56'hF88080F08080F8, 56'hF88080F0808080, 56'h708880B8888878,
		56'h888888F8888888, 56'hF82020202020F8, 56'h38101010109060, 56'h8890A0C0A09088,
		56'h808080808080F8, 56'h88D8A8A8888888, 56'h8888C8A8988888, 56'h70888888888870,
		56'hF08888F0808080, 56'h70888888A89068, 56'hF08888F0A09088, 56'h78808070080_8F0,
		56'hF8202020202020, 56'h88888888888870, 56'h88888888885020, 56'h888888A8A8A850,
		56'h88885020508888, 56'h88888850202020, 56'hF80810204080F8, 56'h70404040404070,
		56'h8850F820F82020, 56'h70101010101070, 56'h20508800000000, 56'h000000000000F8,
		56'h40201000000000, 56'h00007008788878, 56'h8080B0C88888F0, 56'h00007080808870,
		56'h08086898888878, 56'h00007088F88070, 56'h304840E0404040, 56'h00788888780870,
		56'h8080B0C8888888, 56'h20006020202070, 56'h08000808084830, 56'h40404850605048,
		56'h60202020202070, 56'h0000D0A8A88888, 56'h0000B0C8888888, 56'h00007088888870,
		56'h0000F088F08080, 56'h00006898780808, 56'h0000B0C8808080, 56'h000070807008F0,
		56'h4040E040404830, 56'h00008888889868, 56'h00008888885020, 56'h00008888A8A850,
		56'h00008850205088, 56'h00008888780870, 56'h0000F8102040F8, 56'h10202040202010,
		56'h20202020202020, 56'h20101008101020, 56'h002010F8102000, 56'h002040F8402000,
		56'h30484830000000, 56'h30484830000000, 56'h08183878381808, 56'h04040404040404
	};

	// Font row of a character; bytes outside the font show as space.
	function automatic logic [7:0] font_row(input logic [7:0] c, input logic [2:0] row);
		logic [7:0] idx;
		glyph_t g;
		idx = 8'd0;
		if (c >= FONT_FIRST && (c - FONT_FIRST) <= FONT_LAST)
			idx = c - FONT_FIRST;
		g = FONT[idx[6:0]];
		if (row >= 3'd7)
			return 8'h00;
		return g[8 * (6 - int'(row)) +: 8];
	endfunction

endpackage

[hdl/stmd_ram.sv]
// stmd_ram: single-port-write, single-port-read synchronous RAM with a
// registered read; optional per-entry valid bits make unwritten entries read zero.
module stmd_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter bit CLR   = 1'b0,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	if (CLR) begin : g_clr
		logic [DEPTH-1:0] vld_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q <= '0;
			else if (we)
				vld_q[waddr] <= 1'b1;
		end
		always_ff @(posedge clk) begin
			if (re)
				rdata <= vld_q[raddr] ? mem[raddr] : '0;
		end
	end else begin : g_plain
		always_ff @(posedge clk) begin
			if (re)
				rdata <= mem[raddr];
		end
	end

endmodule

[hdl/scrolling_text_matrix_driver.sv]
// scrolling_text_matrix_driver: text store, working bitmap and double frame
// buffer in RAMs, with a sequencer for render, scroll and refresh. Uses stmd_pkg, stmd_ram.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   operation, text_index, text_char
//   out      out_valid / out_stall digit_address, column_bits, row_enable, last_digit
//   cfg      cfg_we                cfg_index, cfg_data
//
// Write character: written into the text store on accept. Render: per digit, a text read, then
// each glyph row written twice (the frame buffer RAM takes one write a cycle, both halves are loaded).
// Scroll step: a text read, then for each glyph row one bitmap read-modify-write per cycle
// across the digits; a tick that does not step leaves the sequencer idle. Refresh: for each
// digit beat, a frame buffer read, then a load of the output register.
// Output beats wait in an output register while out_stall is high; the sequencer
// holds until it frees. Reset clears all control state and valid bits, no sweep.
module scrolling_text_matrix_driver #(
	parameter int MAX_DIGITS    = stmd_pkg::MAX_DIGITS_DEF,
	parameter int GLYPH_ROWS    = stmd_pkg::GLYPH_ROWS_DEF,
	parameter int GLYPH_COLUMNS = stmd_pkg::GLYPH_COLUMNS_DEF,
	parameter int TEXT_DEPTH    = stmd_pkg::TEXT_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [5:0] text_index,
	input  logic [7:0] text_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] digit_address,
	output logic [7:0] column_bits,
	output logic [7:0] row_enable,
	output logic       last_digit,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import stmd_pkg::*;

	localparam int CELLS = MAX_DIGITS * GLYPH_ROWS;
	localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int FW    = $clog2(2 * CELLS);
	localparam int TW    = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int DW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int KW    = $clog2(MAX_DIGITS + 2);
	localparam int ENTRY = 8 - GLYPH_COLUMNS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RRD   = 3'd1;
	localparam logic [2:0] S_RWR   = 3'd2;
	localparam logic [2:0] S_SRD   = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_FRD   = 3'd5;
	localparam logic [2:0] S_FLD   = 3'd6;

	logic [2:0]    state_q;
	logic [7:0]    start_q, speed_q, tick_q, prev_q;
	logic [4:0]    dcount_q;
	logic [6:0]    tlen_q;
	logic          shown_q, swap_q, h_q, ovalid_q;
	logic [2:0]    phase_q, scan_q, r_q;
	logic [TW-1:0] pos_q;
	logic [DW-1:0] d_q;
	logic [KW-1:0] k_q;

	logic [6:0]    ndig;
	logic [8:0]    eff_len;
	logic [TW-1:0] pos_next;
	logic [DW-1:0] last_d;
	logic          accept, out_free;
	logic [7:0]    tdec;

	logic          txt_we, txt_re, wb_we, wb_re, fb_we, fb_re;
	logic [TW-1:0] txt_waddr, txt_raddr;
	logic [7:0]    txt_rdata, wb_rdata, fb_rdata, wb_wdata, glyph;
	logic [CW-1:0] wb_waddr, wb_raddr;
	logic [FW-1:0] fb_waddr, fb_raddr;

	function automatic logic [CW-1:0] cell_at(input int r, input int d);
		return CW'(r * MAX_DIGITS + d);
	endfunction

	function automatic logic [FW-1:0] fb_at(input logic b, input logic [CW-1:0] c);
		return FW'(int'(b) * CELLS + int'(c));
	endfunction

	function automatic logic [7:0] shift_in(input logic [7:0] p, input logic b);
		logic [7:0] v;
		v = {p[6:0], 1'b0};
		v[ENTRY] = b;
		return v;
	endfunction

	always_comb begin
		ndig = 7'(dcount_q);
		if (dcount_q == 5'd0)
			ndig = 7'd1;
		else if (int'(dcount_q) > MAX_DIGITS)
			ndig = 7'(MAX_DIGITS);
		eff_len = 9'(tlen_q);
		if (tlen_q == 7'd0)
			eff_len = 9'd1;
		else if (int'(tlen_q) > TEXT_DEPTH)
			eff_len = 9'(TEXT_DEPTH);
	end

	assign last_d   = DW'(ndig - 7'd1);
	assign pos_next = (9'(pos_q) + 9'd1 >= eff_len) ? '0 : pos_q + TW'(1);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !ovalid_q || !out_stall;
	assign out_valid = ovalid_q;
	assign tdec     = tick_q - 8'd1;
	assign glyph    = font_row(txt_rdata, r_q);

	always_comb begin
		txt_we = 1'b0; txt_re = 1'b0;
		txt_waddr = TW'(text_index);
		txt_raddr = pos_q;
		wb_we = 1'b0; wb_re = 1'b0;
		wb_waddr = cell_at(int'(r_q), int'(d_q));
		wb_raddr = cell_at(int'(r_q), int'(k_q));
		wb_wdata = glyph;
		fb_we = 1'b0; fb_re = 1'b0;
		fb_waddr = fb_at(h_q, wb_waddr);
		fb_raddr = fb_at(shown_q, cell_at(int'(scan_q), int'(d_q)));
		unique case (state_q)
			S_IDLE: begin
				txt_we = accept && operation == OP_WRITE && int'(text_index) < TEXT_DEPTH;
			end
			S_RRD, S_SRD: begin
				txt_re = 1'b1;
			end
			S_RWR: begin
				wb_we = !h_q;
				fb_we = 1'b1;
			end
			S_SHIFT: begin
				wb_re = int'(k_q) < int'(ndig);
				if (int'(k_q) >= 2 && int'(k_q) <= int'(ndig)) begin
					wb_we    = 1'b1;
					wb_waddr = cell_at(int'(r_q), int'(k_q) - 2);
					wb_wdata = shift_in(prev_q, wb_rdata[7]);
				end else if (int'(k_q) == int'(ndig) + 1) begin
					wb_we    = 1'b1;
					wb_waddr = cell_at(int'(r_q), int'(ndig) - 1);
					wb_wdata = shift_in(prev_q, glyph[3'(3'd7 - phase_q)]);
				end
				fb_we    = wb_we;
				fb_waddr = fb_at(!shown_q, wb_waddr);
			end
			S_FRD: begin
				fb_re = 1'b1;
			end
			S_FLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			start_q  <= 8'd0;
			dcount_q <= 5'd1;
			tlen_q   <= 7'd1;
			speed_q  <= 8'd0;
			tick_q   <= 8'd0;
			prev_q   <= 8'd0;
			shown_q  <= 1'b0;
			swap_q   <= 1'b0;
			phase_q  <= 3'd0;
			pos_q    <= '0;
			scan_q   <= 3'd0;
			d_q      <= '0;
			r_q      <= 3'd0;
			h_q      <= 1'b0;
			k_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall)
				ovalid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_START:  start_q  <= cfg_data;
					REG_DIGITS: dcount_q <= cfg_data[4:0];
					REG_LENGTH: tlen_q   <= cfg_data[6:0];
					REG_SPEED: begin
						speed_q <= cfg_data;
						tick_q  <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						d_q <= '0;
						r_q <= 3'd0;
						h_q <= 1'b0;
						k_q <= '0;
						case (operation)
							OP_RENDER: begin
								pos_q   <= '0;
								state_q <= S_RRD;
							end
							OP_SCROLL: begin
								if (speed_q != 8'd0)
									tick_q <= tdec;
								if (speed_q == 8'd0 || tdec == 8'd0) begin
									tick_q <= speed_q;
									if (!swap_q) begin
										if (speed_q == 8'd0)
											swap_q <= 1'b1;
										else
											state_q <= S_SRD;
									end
								end
							end
							OP_REFRESH: state_q <= S_FRD;
							default: begin
							end
						endcase
					end
				end
				S_RRD: state_q <= S_RWR;
				S_RWR: begin
					h_q <= !h_q;
					if (h_q) begin
						if (int'(r_q) == GLYPH_ROWS - 1) begin
							r_q <= 3'd0;
							if (d_q == last_d) begin
								pos_q   <= '0;
								phase_q <= 3'd0;
								tick_q  <= speed_q;
								state_q <= S_IDLE;
							end else begin
								pos_q   <= pos_next;
								d_q     <= d_q + DW'(1);
								state_q <= S_RRD;
							end
						end else begin
							r_q <= r_q + 3'd1;
						end
					end
				end
				S_SRD: state_q <= S_SHIFT;
				S_SHIFT: begin
					if (int'(k_q) >= 1 && int'(k_q) <= int'(ndig))
						prev_q <= wb_rdata;
					if (int'(k_q) == int'(ndig) + 1) begin
						k_q <= '0;
						if (int'(r_q) == GLYPH_ROWS - 1) begin
							r_q     <= 3'd0;
							swap_q  <= 1'b1;
							state_q <= S_IDLE;
							if (int'(phase_q) + 1 >= GLYPH_COLUMNS) begin
								phase_q <= 3'd0;
								pos_q   <= pos_next;
							end else begin
								phase_q <= phase_q + 3'd1;
							end
						end else begin
							r_q <= r_q + 3'd1;
						end
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_FRD: state_q <= S_FLD;
				S_FLD: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (d_q == last_d) begin
							state_q <= S_IDLE;
							if (int'(scan_q) + 1 >= GLYPH_ROWS) begin
								scan_q <= 3'd0;
								if (swap_q) begin
									shown_q <= !shown_q;
									swap_q  <= 1'b0;
								end
							end else begin
								scan_q <= scan_q + 3'd1;
							end
						end else begin
							d_q     <= d_q + DW'(1);
							state_q <= S_FRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (state_q == S_FLD && out_free) begin
			digit_address <= start_q + 8'(d_q);
			column_bits   <= ~fb_rdata;
			row_enable    <= ROW_SELECT_BASE << scan_q;
			last_digit    <= (d_q == last_d);
		end
	end

	stmd_ram #(.DEPTH(TEXT_DEPTH), .WIDTH(8), .CLR(1'b0)) u_text (
		.clk, .arst_n, .we(txt_we), .waddr(txt_waddr), .wdata(text_char),
		.re(txt_re), .raddr(txt_raddr), .rdata(txt_rdata)
	);

	stmd_ram #(.DEPTH(CELLS), .WIDTH(8), .CLR(1'b1)) u_work (
		.clk, .arst_n, .we(wb_we), .waddr(wb_waddr), .wdata(wb_wdata),
		.re(wb_re), .raddr(wb_raddr), .rdata(wb_rdata)
	);

	stmd_ram #(.DEPTH(2 * CELLS), .WIDTH(8), .CLR(1'b1)) u_frame (
		.clk, .arst_n, .we(fb_we), .waddr(fb_waddr), .wdata(wb_wdata),
		.re(fb_re), .raddr(fb_raddr), .rdata(fb_rdata)
	);

endmodule

[sim/scrolling_text_matrix_driver_test.sv]
// Self-checking test of scrolling_text_matrix_driver: directed text, render, scroll and
// refresh beats, then random phases across register settings. Needs stmd_pkg and the RTL.
module scrolling_text_matrix_driver_test;
	timeunit 1ns;
	timeprecision 1ps;
	import stmd_pkg::*;

	localparam int NDIG = MAX_DIGITS_DEF;
	localparam int NROW = GLYPH_ROWS_DEF;
	localparam int NCOL = GLYPH_COLUMNS_DEF;
	localparam int DEPTH = TEXT_DEPTH_DEF;
	localparam int CELLS = NDIG * NROW;
	localparam int SETTLE = 400;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] addr;
		logic [7:0] bits;
		logic [7:0] rsel;
		logic       last;
	} row_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] operation = OP_WRITE;
	logic [5:0] text_index = '0;
	logic [7:0] text_char = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] digit_address;
	logic [7:0] column_bits;
	logic [7:0] row_enable;
	logic       last_digit;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_START;
	logic [7:0] cfg_data = '0;

	scrolling_text_matrix_driver dut (.*);

	initial forever #2 clk = ~clk;

	// shadow of the block
	logic [7:0] m_start, m_speed;
	logic [4:0] m_digits;
	logic [6:0] m_length;
	logic [7:0] text_mem [DEPTH];
	bit         text_set [DEPTH];
	logic [7:0] bitmap [CELLS];
	logic [7:0] frame [2][CELLS];
	bit         shown, swap_due;
	int         col_phase, text_pos, scan_row;
	logic [7:0] tick_cnt;

	row_beat_t  row_beats_due [$];
	int         errors = 0;
	int         burst_left = 0;
	int         idle_cycles = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int digits_used();
		if (m_digits == 0) return 1;
		return (m_digits > NDIG) ? NDIG : int'(m_digits);
	endfunction

	function automatic int length_used();
		if (m_length == 0) return 1;
		return (m_length > DEPTH) ? DEPTH : int'(m_length);
	endfunction

	function automatic logic [7:0] glyph(input int pos, input int row);
		logic [7:0] c;
		int gi;
		glyph_t g;
		c = (pos < DEPTH) ? text_mem[pos] : 8'd0;
		gi = (c >= 32 && c <= 32 + 99) ? int'(c) - 32 : 0;
		g = FONT[gi];
		if (row >= 7) return 8'h00;
		return g[8 * (6 - row) +: 8];
	endfunction

	function automatic void next_char();
		text_pos++;
		if (text_pos >= length_used()) text_pos = 0;
	endfunction

	function automatic void do_render();
		int nd;
		logic [7:0] v;
		nd = digits_used();
		text_pos = 0;
		for (int d = 0; d < nd; d++) begin
			for (int r = 0; r < NROW; r++) begin
				v = glyph(text_pos, r);
				bitmap[r * NDIG + d] = v;
				frame[0][r * NDIG + d] = v;
				frame[1][r * NDIG + d] = v;
			end
			next_char();
		end
		text_pos = 0;
		col_phase = 0;
		tick_cnt = m_speed;
	endfunction

	function automatic void do_scroll();
		int nd, b;
		logic [7:0] v;
		logic [7:0] gr;
		logic fed;
		nd = digits_used();
		if (m_speed != 0) begin
			tick_cnt = tick_cnt - 8'd1;
			if (tick_cnt != 0) return;
		end
		tick_cnt = m_speed;
		if (swap_due) return;
		if (m_speed != 0) begin
			for (int r = 0; r < NROW; r++) begin
				b = r * NDIG;
				for (int k = 0; k < nd; k++) begin
					v = bitmap[b + k] << 1;
					if (k + 1 < nd) begin
						fed = bitmap[b + k + 1][7];
					end else begin
						gr = glyph(text_pos, r);
						fed = gr[7 - col_phase];
					end
					v[8 - NCOL] = fed;
					bitmap[b + k] = v;
					frame[~shown][b + k] = v;
				end
			end
			col_phase++;
			if (col_phase >= NCOL) begin
				next_char();
				col_phase = 0;
			end
		end
		swap_due = 1'b1;
	endfunction

	function automatic void do_refresh();
		int nd;
		row_beat_t e;
		nd = digits_used();
		for (int d = 0; d < nd; d++) begin
			e.addr = m_start + 8'(d);
			e.bits = ~frame[shown][scan_row * NDIG + d];
			e.rsel = ROW_SELECT_BASE << scan_row;
			e.last = (d + 1 == nd);
			row_beats_due.push_back(e);
		end
		scan_row++;
		if (scan_row >= NROW) begin
			scan_row = 0;
			if (swap_due) begin
				shown = ~shown;
				swap_due = 1'b0;
			end
		end
	endfunction

	// first text entry that a render or scroll could read but was never written
	function automatic int unwritten_entry();
		int top;
		top = (text_pos > length_used() - 1) ? text_pos : length_used() - 1;
		for (int i = 0; i <= top && i < DEPTH; i++)
			if (!text_set[i]) return i;
		return -1;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [5:0] idx, input logic [7:0] ch);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		operation <= op;
		text_index <= idx;
		text_char <= ch;
		do @(posedge clk); while (in_stall);
		burst_left--;
		case (op)
			OP_WRITE: begin
				text_mem[idx] = ch;
				text_set[idx] = 1'b1;
			end
			OP_RENDER: do_render();
			OP_SCROLL: do_scroll();
			default: do_refresh();
		endcase
	endtask

	// drop valid, wait for every row beat, then let the sequencer finish
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (row_beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_START: m_start = val;
			REG_DIGITS: m_digits = val[4:0];
			REG_LENGTH: m_length = val[6:0];
			default: begin
				m_speed = val;
				tick_cnt = val;
			end
		endcase
	endtask

	task automatic set_regs(input int sa, input int nd, input int len, input int spd);
		write_reg(REG_START, 8'(sa));
		write_reg(REG_DIGITS, 8'(nd));
		write_reg(REG_LENGTH, 8'(len));
		write_reg(REG_SPEED, 8'(spd));
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_frame();
		for (int i = 0; i < NROW; i++) send_item(OP_REFRESH, 6'h3f, 8'hff);
		drain();
	endtask

	task automatic test_directed();
		set_regs(255, 3, 4, 1);
		send_item(OP_WRITE, 6'd0, 8'd65);
		send_item(OP_WRITE, 6'd1, 8'd131);
		send_item(OP_WRITE, 6'd2, 8'd255);
		send_item(OP_WRITE, 6'd3, 8'd31);
		send_item(OP_WRITE, 6'd63, 8'd32);
		send_item(OP_RENDER, 6'd0, 8'd0);
		for (int i = 0; i < NROW; i++) send_item(OP_REFRESH, 6'd0, 8'd0);
		send_item(OP_SCROLL, 6'd0, 8'd0);
		send_item(OP_SCROLL, 6'd0, 8'd0);  // swap still pending: no step
		for (int i = 0; i < NROW; i++) send_item(OP_REFRESH, 6'd0, 8'd0);
		drain();
	endtask

	task automatic test_random_phase(input int sa, input int nd, input int len, input int spd,
			input int count);
		int pick, hole;
		set_regs(sa, nd, len, spd);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_item(OP_WRITE, 6'($urandom), 8'($urandom));
			end else if (pick < 60) begin
				hole = unwritten_entry();
				if (hole >= 0)
					send_item(OP_WRITE, 6'(hole), 8'($urandom_range(32, 131)));
				else
					send_item((pick < 18) ? OP_RENDER : OP_SCROLL, 6'($urandom), 8'($urandom));
			end else begin
				send_item(OP_REFRESH, 6'($urandom), 8'($urandom));
			end
		end
		drain();
	endtask

	// receiver: alternating stretches of no stall, random stall and long stalls
	int stall_cycle = 0;
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		case ((stall_cycle / 97) % 3)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= ((stall_cycle % 11) < 7);
		endcase
	end

	always @(posedge clk) begin
		row_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (row_beats_due.size() == 0) begin
				report("unexpected beat", digit_address, 0);
			end else begin
				e = row_beats_due.pop_front();
				if (digit_address !== e.addr) report("digit_address", digit_address, e.addr);
				if (column_bits !== e.bits) report("column_bits", column_bits, e.bits);
				if (row_enable !== e.rsel) report("row_enable", row_enable, e.rsel);
				if (last_digit !== e.last) report("last_digit", last_digit, e.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		m_start = 8'd0;
		m_digits = 5'd1;
		m_length = 7'd1;
		m_speed = 8'd0;
		tick_cnt = 8'd0;
		shown = 1'b0;
		swap_due = 1'b0;
		col_phase = 0;
		text_pos = 0;
		scan_row = 0;
		for (int i = 0; i < DEPTH; i++) begin
			text_mem[i] = 8'd0;
			text_set[i] = 1'b0;
		end
		for (int i = 0; i < CELLS; i++) begin
			bitmap[i] = 8'd0;
			frame[0][i] = 8'd0;
			frame[1][i] = 8'd0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frame();
		test_directed();
		test_random_phase($urandom, 1, 1, 0, 16);
		test_random_phase(0, 16, 64, 2, 20);
		test_random_phase(255, 0, 0, 1, 16);
		test_random_phase($urandom, 31, 127, 3, 16);
		test_random_phase($urandom, $urandom_range(1, 16), $urandom_range(1, 64), 255, 16);
		test_random_phase($urandom, $urandom_range(1, 16), $urandom_range(1, 64),
			$urandom_range(1, 4), 17);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
